// ----- hw/rtl/sprs_pkg.sv -----
// Shared types and constants for the session peak record store.
// No dependencies; imported by session_peak_record_store.
package sprs_pkg;

   // Command codes carried on the request side
   typedef enum logic {
      CMD_APPLY = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   localparam int unsigned SampleWidth  = 16;
   localparam int unsigned CountWidthOut = 4;

   // Request tuser, lowest bit first: command, start_session, sample_valid
   typedef struct packed {
      logic    sample_valid;
      logic    start_session;
      cmd_type command;
   } req_user_type;

   // Request tdata, lowest bits first: pack_current, cell_spread_mv
   typedef struct packed {
      logic        [SampleWidth-1:0] cell_spread_mv;
      logic signed [SampleWidth-1:0] pack_current;
   } req_data_type;

   // Response tdata, lowest bits first: record_count, peak_current,
   // peak_spread, zero padding to 40 bits
   typedef struct packed {
      logic        [3:0]             pad;
      logic        [SampleWidth-1:0] peak_spread;
      logic signed [SampleWidth-1:0] peak_current;
      logic        [CountWidthOut-1:0] record_count;
   } rsp_data_type;

   // Magnitude of a 16-bit two's complement value, full-scale negative
   // gives 32768
   function automatic logic [SampleWidth:0] magnitude(
      input logic [SampleWidth-1:0] value
   );
      logic [SampleWidth:0] ext;
      ext = {1'b0, value};
      if (value[SampleWidth-1]) begin
         return (SampleWidth+1)'(1 << SampleWidth) - ext;
      end
      return ext;
   endfunction

endpackage

// ----- hw/rtl/session_peak_record_store.sv -----
// Top level of the session peak record store.
// Depends on sprs_pkg for beat layouts, command codes and the magnitude helper.
//
// Usage:
//   The req_ channel carries one sample or command per beat. tuser selects
//   apply/clear and flags session start and sample validity; tdata holds
//   the pack current and cell spread. The rsp_ channel returns one beat per
//   request: changed flag in tuser, record count and the peak snapshots of
//   the newest record in tdata.
//   The result of a beat accepted at an edge is registered at that edge
//   and valid after it. Throughput is one beat per cycle while the receiver
//   takes each result; the update of the newest record (two compares and a
//   count step) is done combinationally between acceptance and the result register.
//   Only the newest record is ever visible on the result channel, so it is
//   held in flip-flops; dropping the oldest record when the store is full
//   amounts to holding the count at MAX_RECORDS.
//   Reset empties the store and ends any session; no sweep is needed and a
//   request can be taken in the first cycle after reset.
//   When the receiver stalls, the result is held and req_tready drops until
//   the held beat is taken.
module session_peak_record_store
   import sprs_pkg::*;
#(
   parameter int unsigned MAX_RECORDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pack_current[15:0], cell_spread_mv[31:16]
   input  logic [2:0]  req_tuser,   // command[0], start_session[1], sample_valid[2]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // record_count[3:0], peak_current[19:4],
                                    // peak_spread[35:20], zero[39:36]
   output logic        rsp_tuser    // changed[0]
);

   localparam int unsigned CountWidth = $clog2(MAX_RECORDS + 1);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_RECORDS);

   req_user_type req_user;
   req_data_type req_data;
   logic         accept;

   // session state and newest record
   logic [CountWidth-1:0]  held_ff, held_in;
   logic                   session_ff, session_in;
   logic [SampleWidth-1:0] top_cur_ff, top_cur_in;
   logic [SampleWidth-1:0] top_spread_ff, top_spread_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         rsp_changed_ff, rsp_changed_in;

   logic is_clear, do_sample, open_rec, upd_cur, upd_spread;

   assign req_user   = req_user_type'(req_tuser);
   assign req_data   = req_data_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // decode of the beat and peak compares
   always_comb begin
      is_clear   = (req_user.command == CMD_CLEAR);
      do_sample  = !is_clear && req_user.sample_valid;
      open_rec   = do_sample &&
                   (req_user.start_session || !session_ff || (held_ff == '0));
      upd_cur    = do_sample && !open_rec &&
                   (magnitude(req_data.pack_current) > magnitude(top_cur_ff));
      upd_spread = do_sample && !open_rec &&
                   (req_data.cell_spread_mv > top_spread_ff);
   end

   // next state of the store
   always_comb begin
      held_in       = held_ff;
      session_in    = session_ff;
      top_cur_in    = top_cur_ff;
      top_spread_in = top_spread_ff;
      if (accept) begin
         priority if (is_clear) begin
            held_in    = '0;
            session_in = 1'b0;
         end else if (open_rec) begin
            // full store drops its oldest record, count stays at the limit
            held_in       = (held_ff >= MaxCount) ? MaxCount : held_ff + CountWidth'(1);
            session_in    = 1'b1;
            top_cur_in    = req_data.pack_current;
            top_spread_in = req_data.cell_spread_mv;
         end else begin
            if (upd_cur) begin
               top_cur_in = req_data.pack_current;
            end
            if (upd_spread) begin
               top_spread_in = req_data.cell_spread_mv;
            end
         end
      end
   end

   // result beat
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_changed_in = rsp_changed_ff;
      if (accept) begin
         rsp_valid_in             = 1'b1;
         rsp_changed_in           = open_rec || upd_cur || upd_spread;
         rsp_data_in.pad          = '0;
         rsp_data_in.record_count = CountWidthOut'(held_in);
         if (held_in != '0) begin
            rsp_data_in.peak_current = top_cur_in;
            rsp_data_in.peak_spread  = top_spread_in;
         end else begin
            rsp_data_in.peak_current = '0;
            rsp_data_in.peak_spread  = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         session_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         session_ff   <= session_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_cur_ff     <= top_cur_in;
      top_spread_ff  <= top_spread_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_changed_ff;

   // count never passes the store depth
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= MaxCount)
      else $error("record count beyond store depth");

   // a clear empties the store and ends the session
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && is_clear |=> (held_ff == '0) && !session_ff)
      else $error("clear did not empty the store");

   // an opened record starts a session and leaves the store non-empty
   a_open: assert property (@(posedge clock) disable iff (reset)
      accept && open_rec |=> session_ff && (held_ff != '0) && rsp_changed_ff)
      else $error("record open not reflected in state");

   // every accepted beat yields a result beat
   a_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

endmodule

// ----- test/session_peak_record_store_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for session_peak_record_store: random stalls on both
// stream sides, with an in-bench tracker that predicts every result beat.
// Depends on sprs_pkg for beat layouts and command codes.
module session_peak_record_store_tb;
   import sprs_pkg::*;

   localparam int unsigned MaxRecords   = 8;
   localparam int unsigned StallLimit   = 2000;
   localparam int unsigned RandomBeats  = 1300;
   localparam int unsigned RandomPhases = 4;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // pack_current[15:0], cell_spread_mv[31:16]
   logic [2:0]  req_tuser;   // command[0], start_session[1], sample_valid[2]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // record_count[3:0], peak_current[19:4],
                             // peak_spread[35:20], zero[39:36]
   logic        rsp_tuser;   // changed[0]

   // no idle cycles on either side while set
   bit quiet_phase = 1'b0;

   typedef struct packed {
      logic                    changed;
      logic [3:0]              count;
      logic signed [15:0]      current;
      logic [15:0]             spread;
   } peak_result_type;

   // Tracks the record history and queues the result beat each request causes
   class peak_record_tracker;
      logic signed [15:0] rec_current[MaxRecords];
      logic [15:0]        rec_spread[MaxRecords];
      int unsigned        held = 0;
      bit                 session_open = 1'b0;
      peak_result_type    predicted[$];
      int unsigned        mismatches = 0;
      int unsigned        checked = 0;
      int unsigned        opened = 0;
      int unsigned        updates = 0;
      int unsigned        clears = 0;

      function int unsigned pending();
         return predicted.size();
      endfunction

      // full-scale negative current ranks above every positive value
      function int unsigned abs_current(logic signed [15:0] value);
         int wide;
         wide = value;
         return (wide < 0) ? -wide : wide;
      endfunction

      function void note_request(logic [2:0] user, logic [31:0] data);
         req_user_type u;
         req_data_type d;
         peak_result_type r;
         u = user;
         d = data;
         r = '0;
         if (u.command == CMD_CLEAR) begin
            held = 0;
            session_open = 1'b0;
            clears++;
         end else if (u.sample_valid) begin
            if (u.start_session) session_open = 1'b0;
            if (!session_open || held == 0) begin
               // full store: oldest record drops out
               if (held == MaxRecords) begin
                  for (int i = 0; i + 1 < MaxRecords; i++) begin
                     rec_current[i] = rec_current[i+1];
                     rec_spread[i]  = rec_spread[i+1];
                  end
                  held = MaxRecords - 1;
               end
               rec_current[held] = d.pack_current;
               rec_spread[held]  = d.cell_spread_mv;
               held++;
               session_open = 1'b1;
               r.changed = 1'b1;
               opened++;
            end else begin
               if (abs_current(d.pack_current) > abs_current(rec_current[held-1])) begin
                  rec_current[held-1] = d.pack_current;
                  r.changed = 1'b1;
               end
               if (d.cell_spread_mv > rec_spread[held-1]) begin
                  rec_spread[held-1] = d.cell_spread_mv;
                  r.changed = 1'b1;
               end
               if (r.changed) updates++;
            end
         end
         r.count = held[3:0];
         if (held > 0) begin
            r.current = rec_current[held-1];
            r.spread  = rec_spread[held-1];
         end
         predicted.push_back(r);
      endfunction

      function void flag(string field, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on result beat %0d, %s: expected %0d, got %0d",
                     checked, field, want, got);
      endfunction

      function void check_response(logic [39:0] data, logic user);
         rsp_data_type d;
         peak_result_type e;
         d = data;
         if (predicted.size() == 0) begin
            flag("unexpected beat, record_count", -1, d.record_count);
            return;
         end
         e = predicted.pop_front();
         checked++;
         if (user !== e.changed)              flag("changed", e.changed, user);
         if (d.record_count !== e.count)      flag("record_count", e.count, d.record_count);
         if (d.peak_current !== e.current)    flag("peak_current", e.current, d.peak_current);
         if (d.peak_spread !== e.spread)      flag("peak_spread", e.spread, d.peak_spread);
         if (d.pad !== 4'd0)                  flag("padding", 0, d.pad);
      endfunction
   endclass

   peak_record_tracker tracker;

   session_peak_record_store #(
      .MAX_RECORDS(MaxRecords)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Beat monitor: retire the result first, then queue the new prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) tracker.note_request(req_tuser, req_tdata);
      end
   end

   // Watchdog: ends the run once nothing has moved for too long
   initial begin
      int unsigned stalled;
      stalled = 0;
      while (stalled < StallLimit) begin
         @(posedge clock);
         if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
            stalled = 0;
         else
            stalled++;
      end
      $display("timeout: no beat accepted for %0d cycles", StallLimit);
      $display("session_peak_record_store_tb failed");
      $finish;
   end

   // Result side: random back-pressure per beat
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Drive one request beat; returns at the falling edge after acceptance
   task automatic send_beat(cmd_type cmd, bit start, bit valid,
                            logic [15:0] current, logic [15:0] spread);
      int unsigned gap;
      req_user_type u;
      req_data_type d;
      u.command = cmd;
      u.start_session = start;
      u.sample_valid = valid;
      d.pack_current = current;
      d.cell_spread_mv = spread;
      gap = quiet_phase ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = u;
      req_tdata  = d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the sender until every queued result has come back
   task automatic drain();
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   // Field values biased toward the extremes and toward small numbers
   function automatic logic [15:0] draw_value();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         3:       return 16'hFFFF;
         4:       return 16'($urandom_range(0, 255));
         5:       return -16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned counted;
      int unsigned target;
      int unsigned length;
      int unsigned pick;
      tracker    = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty store opens a record even without a session start
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h0000, 16'h0000);
      // invalid beat: start flag must not take effect
      send_beat(CMD_APPLY, 1'b1, 1'b0, 16'h8000, 16'hFFFF);
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h7FFF, 16'h0001);
      // full-scale negative beats the largest positive
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h8000, 16'h0000);
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h7FFF, 16'h0001);
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h8000, 16'hFFFF);
      // equal values do not replace a peak
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h8000, 16'hFFFF);
      // clear ignores every other field
      send_beat(CMD_CLEAR, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'h0005, 16'h0005);
      send_beat(CMD_APPLY, 1'b0, 1'b1, 16'hFFFB, 16'h0005);
      send_beat(CMD_APPLY, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
      // overfill the store so the oldest records drop out
      for (int i = 0; i < 8; i++)
         send_beat(CMD_APPLY, 1'b1, 1'b1, (i % 2) ? 16'h8000 : 16'(i * 4099),
                   16'(16'hFFFF - i * 977));
      send_beat(CMD_CLEAR, 1'b0, 1'b0, 16'h0000, 16'h0000);
      send_beat(CMD_APPLY, 1'b0, 1'b0, 16'h1234, 16'h5678);
      drain();

      // Random sessions with some clears and noise; one phase without idling
      for (int phase = 0; phase < RandomPhases; phase++) begin
         quiet_phase = (phase == 2);
         target = RandomBeats / RandomPhases;
         counted = 0;
         while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               send_beat(CMD_CLEAR, 1'($urandom), 1'($urandom), draw_value(), draw_value());
               counted++;
            end else if (pick < 8) begin
               send_beat(CMD_APPLY, 1'($urandom), 1'b0, draw_value(), draw_value());
            end else begin
               length = $urandom_range(1, 12);
               send_beat(CMD_APPLY, ($urandom_range(0, 9) != 0), 1'b1,
                         draw_value(), draw_value());
               counted++;
               for (int k = 1; k < length; k++) begin
                  if ($urandom_range(0, 9) == 0) begin
                     send_beat(CMD_APPLY, 1'($urandom), 1'b0, draw_value(), draw_value());
                  end else begin
                     send_beat(CMD_APPLY, 1'b0, 1'b1, draw_value(), draw_value());
                     counted++;
                  end
               end
            end
         end
         drain();
      end
      quiet_phase = 1'b0;

      // idle wait after draining catches any stray result beat
      repeat (4) @(posedge clock);
      $display("covered %0d records opened, %0d peak updates and %0d clears",
               tracker.opened, tracker.updates, tracker.clears);
      $display("%0d result beats checked, %0d mismatches",
               tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("session_peak_record_store_tb passed");
      end else begin
         $display("session_peak_record_store_tb failed");
      end
      $finish;
   end

endmodule
